>>> rtl/midpoint_ellipse_rasterizer_macros.svh
// Assertion helpers for the ellipse rasteriser.
// Both expect signals named clk and rst in the scope of use.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Same-cycle implication
`define MER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mer_pkg.sv
package mer_pkg;

  // Default geometry
  localparam int AXIS_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 11;

  // Datapath operation codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
  localparam logic [OP_W-1:0] OP_RESTART    = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL_AA     = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL_BB     = 5'd3;
  localparam logic [OP_W-1:0] OP_INIT_D     = 5'd4;
  localparam logic [OP_W-1:0] OP_INIT_DY    = 5'd5;
  localparam logic [OP_W-1:0] OP_INIT_FIN   = 5'd6;
  localparam logic [OP_W-1:0] OP_R1_STEP    = 5'd7;
  localparam logic [OP_W-1:0] OP_ADD_4DX    = 5'd8;
  localparam logic [OP_W-1:0] OP_ADD_4BB    = 5'd9;
  localparam logic [OP_W-1:0] OP_SUB_4DY_BR = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_TX     = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_BB_P   = 5'd12;
  localparam logic [OP_W-1:0] OP_LOAD_D_TY  = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL_AA_P   = 5'd14;
  localparam logic [OP_W-1:0] OP_ADD_4P_AB  = 5'd15;
  localparam logic [OP_W-1:0] OP_SUB_4P_R2  = 5'd16;
  localparam logic [OP_W-1:0] OP_FINISH     = 5'd17;
  localparam logic [OP_W-1:0] OP_R2_STEP    = 5'd18;
  localparam logic [OP_W-1:0] OP_ADD_4AA    = 5'd19;
  localparam logic [OP_W-1:0] OP_SUB_4DY    = 5'd20;
  localparam logic [OP_W-1:0] OP_ADD_4DX_BR = 5'd21;

  // Quadrant order of the four mirrored pixels
  localparam logic [1:0] PIX_PP = 2'd0;  // (h+x, k+y)
  localparam logic [1:0] PIX_PM = 2'd1;  // (h+x, k-y)
  localparam logic [1:0] PIX_MP = 2'd2;  // (h-x, k+y)
  localparam logic [1:0] PIX_MM = 2'd3;  // (h-x, k-y), last of the group

  // Register map (word index)
  localparam logic [1:0] REG_SEMI_AXIS_X = 2'd0;
  localparam logic [1:0] REG_SEMI_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_CENTRE_X    = 2'd2;
  localparam logic [1:0] REG_CENTRE_Y    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            snap;      // capture x, y for the pixel emitter
    logic            load_pix;  // load one pixel into the output register
    logic [1:0]      pix_idx;
  } mer_cmd_t;

  typedef struct packed {
    logic finished;
    logic in_region_two;
    logic dx_lt_dy;
    logic y_neg;
  } mer_status_t;

endpackage

>>> rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasteriser.
// Set the semi-axes and the centre over the APB port, then send a restart
// item on the input channel (in_valid/in_stall, field restart). Each later
// item with restart low performs one iteration and gives four mirrored
// pixels on the output channel (out_valid/out_stall), one transfer each;
// the fourth carries last_of_step, and the final group of the walk also
// carries last_of_ellipse. Register writes apply at the next restart.
// Behaviour, with the output channel not stalled:
//   restart item       five set-up steps after the transfer;
//   region 1 or 2 step first pixel loaded once the emitter holds the
//                      snapshot, next item taken as the fourth pixel is loaded;
//   region change      six multiply/accumulate steps to set up the region 2
//                      decision, then a region 2 step as above;
//   after the end      no pixels.
// The step rate is set by the single decision adder, one term per cycle.
// A stall on the output holds the pixel register and the emitter; the input
// is then stalled once the current item is done. Reset leaves the walk
// finished, so advance items give nothing until a restart.
module midpoint_ellipse_rasterizer #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         restart,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         last_of_ellipse,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mer_pkg::*;

  logic [AXIS_BITS-1:0]  semi_axis_x;
  logic [AXIS_BITS-1:0]  semi_axis_y;
  logic [COORD_BITS-1:0] centre_x;
  logic [COORD_BITS-1:0] centre_y;
  logic                  cfg_wr;
  mer_cmd_t              cmd;
  mer_status_t           status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_axis_x <= '0;
      semi_axis_y <= '0;
      centre_x    <= '0;
      centre_y    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SEMI_AXIS_X: semi_axis_x <= pwdata[AXIS_BITS-1:0];
        REG_SEMI_AXIS_Y: semi_axis_y <= pwdata[AXIS_BITS-1:0];
        REG_CENTRE_X:    centre_x    <= pwdata[COORD_BITS-1:0];
        REG_CENTRE_Y:    centre_y    <= pwdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEMI_AXIS_X: prdata = 32'(semi_axis_x);
      REG_SEMI_AXIS_Y: prdata = 32'(semi_axis_y);
      REG_CENTRE_X:    prdata = 32'(centre_x);
      REG_CENTRE_Y:    prdata = 32'(centre_y);
      default:         prdata = '0;
    endcase
  end

  // Sequencer and pixel emitter control
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Walk arithmetic and output register
  mer_dp #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_a           (semi_axis_x),
    .cfg_b           (semi_axis_y),
    .cfg_h           (centre_x),
    .cfg_k           (centre_y),
    .status          (status),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .last_of_step    (last_of_step),
    .last_of_ellipse (last_of_ellipse)
  );

endmodule

>>> rtl/mer_ctrl.sv
`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_cmd_t    cmd
);
  import mer_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_I1   = 5'd1;
  localparam logic [4:0] S_I2   = 5'd2;
  localparam logic [4:0] S_I3   = 5'd3;
  localparam logic [4:0] S_I4   = 5'd4;
  localparam logic [4:0] S_I5   = 5'd5;
  localparam logic [4:0] S_R1B  = 5'd6;
  localparam logic [4:0] S_R1C  = 5'd7;
  localparam logic [4:0] S_R1D  = 5'd8;
  localparam logic [4:0] S_Q2   = 5'd9;
  localparam logic [4:0] S_Q3   = 5'd10;
  localparam logic [4:0] S_Q4   = 5'd11;
  localparam logic [4:0] S_Q5   = 5'd12;
  localparam logic [4:0] S_Q6   = 5'd13;
  localparam logic [4:0] S_D2   = 5'd14;
  localparam logic [4:0] S_R2B  = 5'd15;
  localparam logic [4:0] S_R2C  = 5'd16;
  localparam logic [4:0] S_R2D  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       emit_busy;
  logic [1:0] emit_idx;
  logic       load;
  logic       last_load;
  logic       accept;

  // Pixel emitter: one pixel per free slot of the output register
  assign load      = emit_busy && (!out_valid || !out_stall);
  assign last_load = load && (emit_idx == PIX_MM);

  // Take an item once the sequencer is idle and the snapshot is (being) freed
  assign in_stall = !((state == S_IDLE) && (!emit_busy || last_load));
  assign accept   = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.snap     = 1'b0;
    cmd.load_pix = load;
    cmd.pix_idx  = emit_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (restart) begin
            cmd.op     = OP_RESTART;
            state_next = S_I1;
          end else if (!status.finished) begin
            if (!status.in_region_two && status.dx_lt_dy) begin
              cmd.snap   = 1'b1;
              cmd.op     = OP_R1_STEP;
              state_next = S_R1B;
            end else if (!status.in_region_two) begin
              cmd.op     = OP_MUL_TX;
              state_next = S_Q2;
            end else if (status.y_neg) begin
              cmd.op = OP_FINISH;
            end else begin
              cmd.snap   = 1'b1;
              cmd.op     = OP_R2_STEP;
              state_next = S_R2B;
            end
          end
        end
      end
      S_I1: begin
        cmd.op     = OP_MUL_AA;
        state_next = S_I2;
      end
      S_I2: begin
        cmd.op     = OP_MUL_BB;
        state_next = S_I3;
      end
      S_I3: begin
        cmd.op     = OP_INIT_D;
        state_next = S_I4;
      end
      S_I4: begin
        cmd.op     = OP_INIT_DY;
        state_next = S_I5;
      end
      S_I5: begin
        cmd.op     = OP_INIT_FIN;
        state_next = S_IDLE;
      end
      S_R1B: begin
        cmd.op     = OP_ADD_4DX;
        state_next = S_R1C;
      end
      S_R1C: begin
        cmd.op     = OP_ADD_4BB;
        state_next = S_R1D;
      end
      S_R1D: begin
        cmd.op     = OP_SUB_4DY_BR;
        state_next = S_IDLE;
      end
      S_Q2: begin
        cmd.op     = OP_MUL_BB_P;
        state_next = S_Q3;
      end
      S_Q3: begin
        cmd.op     = OP_LOAD_D_TY;
        state_next = S_Q4;
      end
      S_Q4: begin
        cmd.op     = OP_MUL_AA_P;
        state_next = S_Q5;
      end
      S_Q5: begin
        cmd.op     = OP_ADD_4P_AB;
        state_next = S_Q6;
      end
      S_Q6: begin
        cmd.op     = OP_SUB_4P_R2;
        state_next = S_D2;
      end
      S_D2: begin
        if (status.y_neg) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end else begin
          cmd.snap   = 1'b1;
          cmd.op     = OP_R2_STEP;
          state_next = S_R2B;
        end
      end
      S_R2B: begin
        cmd.op     = OP_ADD_4AA;
        state_next = S_R2C;
      end
      S_R2C: begin
        cmd.op     = OP_SUB_4DY;
        state_next = S_R2D;
      end
      S_R2D: begin
        cmd.op     = OP_ADD_4DX_BR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, emitter count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_busy <= 1'b0;
      emit_idx  <= PIX_PP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new group may start as the previous one hands over its last pixel
      if (cmd.snap) begin
        emit_busy <= 1'b1;
        emit_idx  <= PIX_PP;
      end else if (load) begin
        emit_idx <= emit_idx + 2'd1;
        if (emit_idx == PIX_MM) begin
          emit_busy <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MER_ASSERT_NOW(a_snap_free, cmd.snap, !emit_busy || last_load, "snapshot taken while emitting")
  `MER_ASSERT_NEXT(a_emit_ends, last_load && !cmd.snap, !emit_busy, "emitter ran past four pixels")
  `MER_ASSERT_NEXT(a_restart_init, accept && restart, state == S_I1, "restart did not start set-up")
  `MER_ASSERT_NOW(a_out_source, $rose(out_valid), $past(emit_busy), "pixel without a group")

endmodule

>>> rtl/mer_dp.sv
module mer_dp #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mer_pkg::mer_cmd_t           cmd,
  input  logic [AXIS_BITS-1:0]        cfg_a,
  input  logic [AXIS_BITS-1:0]        cfg_b,
  input  logic [COORD_BITS-1:0]       cfg_h,
  input  logic [COORD_BITS-1:0]       cfg_k,
  output mer_pkg::mer_status_t        status,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                        last_of_step,
  output logic                        last_of_ellipse
);
  import mer_pkg::*;

  localparam int XW = AXIS_BITS + 1;          // x position
  localparam int YW = AXIS_BITS + 2;          // y position, signed
  localparam int AW = 2 * AXIS_BITS;          // a*a, b*b
  localparam int MW = 2 * AXIS_BITS + 4;      // multiplier operand
  localparam int SW = 3 * AXIS_BITS + 4;      // slopes, signed
  localparam int DW = 4 * AXIS_BITS + 8;      // decision and product
  localparam int PW = COORD_BITS + 2;         // pixel coordinate
  localparam int LW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;
  localparam logic signed [YW-1:0] Y_ONE = YW'(1);

  // Walk state
  logic [AXIS_BITS-1:0]  lat_a;
  logic [AXIS_BITS-1:0]  lat_b;
  logic [COORD_BITS-1:0] lat_h;
  logic [COORD_BITS-1:0] lat_k;
  logic [AW-1:0]         aa;
  logic [AW-1:0]         bb;
  logic [XW-1:0]         cur_x;
  logic signed [YW-1:0]  cur_y;
  logic signed [SW-1:0]  slope_dx;
  logic signed [SW-1:0]  slope_dy;
  logic signed [DW-1:0]  decision;
  logic [DW-1:0]         prod;
  logic                  br;
  logic                  in_region_two;
  logic                  finished;

  // Emitter snapshot
  logic [XW-1:0]         snap_x;
  logic signed [YW-1:0]  snap_y;
  logic                  snap_last;

  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic                  mul_en;
  logic signed [YW-1:0]  ty;
  logic [MW-1:0]         ty_mag;
  logic                  d_neg;
  logic                  d_pos;
  logic                  y_zero;
  logic signed [SW-1:0]  aa2;
  logic signed [SW-1:0]  bb2;
  logic signed [DW-1:0]  aa4;
  logic signed [DW-1:0]  bb4;
  logic signed [DW-1:0]  dx4;
  logic signed [DW-1:0]  dy4;
  logic signed [DW-1:0]  prod4;

  // Scaled terms
  assign aa2   = $signed({{(SW-AW-1){1'b0}}, aa, 1'b0});
  assign bb2   = $signed({{(SW-AW-1){1'b0}}, bb, 1'b0});
  assign aa4   = $signed({{(DW-AW-2){1'b0}}, aa, 2'b00});
  assign bb4   = $signed({{(DW-AW-2){1'b0}}, bb, 2'b00});
  assign dx4   = $signed({{(DW-SW-2){slope_dx[SW-1]}}, slope_dx, 2'b00});
  assign dy4   = $signed({{(DW-SW-2){slope_dy[SW-1]}}, slope_dy, 2'b00});
  assign prod4 = $signed({prod[DW-3:0], 2'b00});

  assign d_neg  = decision[DW-1];
  assign d_pos  = !decision[DW-1] && (decision != '0);
  assign y_zero = (cur_y == '0);

  // |y-1|: y is never negative when region 2 is set up
  assign ty     = cur_y - Y_ONE;
  assign ty_mag = ty[YW-1] ? MW'(1) : {{(MW-YW){1'b0}}, ty};

  assign status.finished      = finished;
  assign status.in_region_two = in_region_two;
  assign status.dx_lt_dy      = (slope_dx < slope_dy);
  assign status.y_neg         = cur_y[YW-1];

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_AA: begin
        mul_a = {{(MW-AXIS_BITS){1'b0}}, lat_a};
        mul_b = {{(MW-AXIS_BITS){1'b0}}, lat_a};
      end
      OP_MUL_BB: begin
        mul_a = {{(MW-AXIS_BITS){1'b0}}, lat_b};
        mul_b = {{(MW-AXIS_BITS){1'b0}}, lat_b};
      end
      OP_INIT_D: begin
        mul_a = {{(MW-AW){1'b0}}, aa};
        mul_b = {{(MW-AXIS_BITS){1'b0}}, lat_b};
      end
      OP_MUL_TX: begin
        mul_a = {{(MW-XW-1){1'b0}}, cur_x, 1'b1};
        mul_b = {{(MW-XW-1){1'b0}}, cur_x, 1'b1};
      end
      OP_MUL_BB_P: begin
        mul_a = {{(MW-AW){1'b0}}, bb};
        mul_b = prod[MW-1:0];
      end
      OP_LOAD_D_TY: begin
        mul_a = ty_mag;
        mul_b = ty_mag;
      end
      OP_MUL_AA_P: begin
        mul_a = {{(MW-AW){1'b0}}, aa};
        mul_b = prod[MW-1:0];
      end
      OP_ADD_4P_AB: begin
        mul_a = {{(MW-AW){1'b0}}, aa};
        mul_b = {{(MW-AW){1'b0}}, bb};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= {{(DW-MW){1'b0}}, mul_a} * {{(DW-MW){1'b0}}, mul_b};
    end
  end

  // Walk registers: one decision add per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      finished      <= 1'b1;
      in_region_two <= 1'b0;
    end else begin
      case (cmd.op)
        OP_RESTART: begin
          lat_a         <= cfg_a;
          lat_b         <= cfg_b;
          lat_h         <= cfg_h;
          lat_k         <= cfg_k;
          cur_x         <= '0;
          cur_y         <= $signed({{(YW-AXIS_BITS){1'b0}}, cfg_b});
          slope_dx      <= '0;
          in_region_two <= 1'b0;
          finished      <= 1'b0;
        end
        OP_MUL_BB: begin
          aa <= prod[AW-1:0];
        end
        OP_INIT_D: begin
          bb       <= prod[AW-1:0];
          decision <= $signed({{(DW-AW){1'b0}}, aa});
        end
        OP_INIT_DY: begin
          decision <= decision + bb4;
          slope_dy <= $signed({prod[SW-2:0], 1'b0});
        end
        OP_INIT_FIN: begin
          decision <= decision - prod4;
        end
        OP_R1_STEP: begin
          cur_x    <= cur_x + XW'(1);
          slope_dx <= slope_dx + bb2;
          br       <= !d_neg;
          if (!d_neg) begin
            cur_y    <= cur_y - Y_ONE;
            slope_dy <= slope_dy - aa2;
          end
        end
        OP_ADD_4DX: begin
          decision <= decision + dx4;
        end
        OP_ADD_4BB: begin
          decision <= decision + bb4;
        end
        OP_SUB_4DY_BR: begin
          if (br) begin
            decision <= decision - dy4;
          end
        end
        OP_LOAD_D_TY: begin
          decision <= $signed(prod);
        end
        OP_ADD_4P_AB: begin
          decision <= decision + prod4;
        end
        OP_SUB_4P_R2: begin
          decision      <= decision - prod4;
          in_region_two <= 1'b1;
        end
        OP_FINISH: begin
          finished <= 1'b1;
        end
        OP_R2_STEP: begin
          cur_y    <= cur_y - Y_ONE;
          slope_dy <= slope_dy - aa2;
          br       <= !d_pos;
          if (!d_pos) begin
            cur_x    <= cur_x + XW'(1);
            slope_dx <= slope_dx + bb2;
          end
          if (y_zero) begin
            finished <= 1'b1;
          end
        end
        OP_ADD_4AA: begin
          decision <= decision + aa4;
        end
        OP_SUB_4DY: begin
          decision <= decision - dy4;
        end
        OP_ADD_4DX_BR: begin
          if (br) begin
            decision <= decision + dx4;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Emitter snapshot of the point being plotted
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_x    <= cur_x;
      snap_y    <= cur_y;
      snap_last <= in_region_two && y_zero;
    end
  end

  // Mirrored pixel coordinates
  logic signed [LW-1:0] h_w;
  logic signed [LW-1:0] k_w;
  logic signed [LW-1:0] x_w;
  logic signed [LW-1:0] y_w;
  logic signed [LW-1:0] hx_plus;
  logic signed [LW-1:0] hx_minus;
  logic signed [LW-1:0] ky_plus;
  logic signed [LW-1:0] ky_minus;

  assign h_w      = $signed({{(LW-COORD_BITS){1'b0}}, lat_h});
  assign k_w      = $signed({{(LW-COORD_BITS){1'b0}}, lat_k});
  assign x_w      = $signed({{(LW-XW){1'b0}}, snap_x});
  assign y_w      = $signed({{(LW-YW){snap_y[YW-1]}}, snap_y});
  assign hx_plus  = h_w + x_w;
  assign hx_minus = h_w - x_w;
  assign ky_plus  = k_w + y_w;
  assign ky_minus = k_w - y_w;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      last_of_step    <= (cmd.pix_idx == PIX_MM);
      last_of_ellipse <= (cmd.pix_idx == PIX_MM) && snap_last;
      case (cmd.pix_idx)
        PIX_PP: begin
          pixel_x <= hx_plus[PW-1:0];
          pixel_y <= ky_plus[PW-1:0];
        end
        PIX_PM: begin
          pixel_x <= hx_plus[PW-1:0];
          pixel_y <= ky_minus[PW-1:0];
        end
        PIX_MP: begin
          pixel_x <= hx_minus[PW-1:0];
          pixel_y <= ky_plus[PW-1:0];
        end
        default: begin
          pixel_x <= hx_minus[PW-1:0];
          pixel_y <= ky_minus[PW-1:0];
        end
      endcase
    end
  end

endmodule
